[sv/multichannel_moving_average_top_defines.svh]
// Assertion macros shared by the moving-average filter RTL.
`ifndef MULTICHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define MMA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("moving average check failed");

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define MMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("moving average check failed");

`endif

[sv/mma_pkg.sv]
// Shared constants, result type and sample packing for the moving-average filter.
package mma_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int NIBBLE_W = 4;

  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0f;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] avg;
  } result_t;

  // The high byte gives sample bits 11..4, the upper nibble of the low byte bits 3..0.
  function automatic logic [SAMPLE_W-1:0] build_sample(input logic [BYTE_W-1:0] hi,
                                                       input logic [BYTE_W-1:0] lo);
    logic [BYTE_W-1:0] nib;
    nib = (lo >> NIBBLE_W) & NIBBLE_MASK;
    return {hi, nib[NIBBLE_W-1:0]};
  endfunction

endpackage

[sv/multichannel_moving_average_top.sv]
// Top level of the multichannel boxcar moving-average filter.
//
// Input channel: in_valid/in_stall with in_channel, in_high_byte, in_low_byte. A transfer
// happens at a rising edge with in_valid high and in_stall low. The 12-bit sample is the
// high byte followed by the upper nibble of the low byte.
// Result channel: out_valid/out_stall with out_result_channel and out_average, which is
// the floor of the mean of the channel's last WINDOW_LENGTH samples.
// Exactly one result transfer follows each input transfer, in order. An item whose channel
// is not present leaves all state alone and returns an average of zero.
// Throughput is one item per cycle while the output buffer is not full, also for
// back-to-back items of the same channel, since the running sum is read and written in
// the same pipeline stage. An accepted item passes the sample memory read and the stage-1
// registers, then the running-sum update into the stage-2 registers, and the reciprocal
// multiply that divides by the window length feeds the output buffer, which drives out_valid.
// Reset (rst_n low, synchronous) clears the write pointers, the per-channel fill flags and
// the running sums. The sample memory is not swept: an entry of a channel whose ring has
// not wrapped yet reads as zero, so no clearing pass is needed and items are taken at once.
// When the receiver stalls, a two-entry output buffer keeps taking results; in_stall rises
// only once both entries hold results, and the whole pipeline then holds.
module multichannel_moving_average_top #(
  parameter int WINDOW_LENGTH = 8,
  parameter int CHANNEL_COUNT = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mma_pkg::CHAN_W-1:0]         in_channel,
  input  logic [mma_pkg::BYTE_W-1:0]         in_high_byte,
  input  logic [mma_pkg::BYTE_W-1:0]         in_low_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mma_pkg::CHAN_W-1:0]         out_result_channel,
  output logic [mma_pkg::SAMPLE_W-1:0]       out_average
);

`include "multichannel_moving_average_top_defines.svh"

  localparam int PTR_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CIDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int ADDR_W  = CIDX_W + PTR_W;
  localparam int SUM_W   = mma_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH);
  // Division by the window length is a multiply by a rounded-up reciprocal. With the
  // shift one window-width beyond the sum width, the quotient is exact for every sum.
  localparam int SHIFT   = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint RECIP = ((longint'(1) << SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam logic [RECIP_W-1:0] RECIP_V  = RECIP_W'(RECIP);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(WINDOW_LENGTH - 1);
  localparam logic [SUM_W-1:0]   MAX_SUM  =
    SUM_W'(((1 << mma_pkg::SAMPLE_W) - 1) * WINDOW_LENGTH);

  // Pipeline control: everything advances together unless the output buffer is full.
  logic adv, buf_full, accept;

  assign adv      = !buf_full;
  assign in_stall = buf_full;
  assign accept   = in_valid && adv;

  // Stage 0: pointer lookup and sample memory access.
  logic [CIDX_W-1:0]           in_idx;
  logic                        in_live;
  logic [PTR_W-1:0]            cur_ptr, ptr_nxt;
  logic                        cur_filled;
  logic [mma_pkg::SAMPLE_W-1:0] in_sample;
  logic [PTR_W-1:0]            ptr_r    [CHANNEL_COUNT];
  logic                        filled_r [CHANNEL_COUNT];
  logic                        ram_en;
  logic [mma_pkg::SAMPLE_W-1:0] ram_rdata;

  assign in_idx     = CIDX_W'(in_channel);
  assign in_live    = int'(in_channel) < CHANNEL_COUNT;
  assign cur_ptr    = ptr_r[in_idx];
  assign cur_filled = filled_r[in_idx];
  assign ptr_nxt    = (cur_ptr == PTR_LAST) ? '0 : cur_ptr + 1'b1;
  assign in_sample  = mma_pkg::build_sample(in_high_byte, in_low_byte);
  assign ram_en     = accept && in_live;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        ptr_r[i]    <= '0;
        filled_r[i] <= 1'b0;
      end
    end else if (ram_en) begin
      ptr_r[in_idx] <= ptr_nxt;
      if (cur_ptr == PTR_LAST) begin
        filled_r[in_idx] <= 1'b1;
      end
    end
  end

  mma_ring_ram #(
    .ADDR_W (ADDR_W)
  ) u_ring_ram (
    .clk   (clk),
    .en    (ram_en),
    .addr  ({in_idx, cur_ptr}),
    .wdata (in_sample),
    .rdata (ram_rdata)
  );

  // Stage 1: running-sum update with the overwritten sample.
  logic                         s1_valid_r, s1_live_r, s1_filled_r;
  logic [mma_pkg::CHAN_W-1:0]   s1_chan_r;
  logic [mma_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic [mma_pkg::SAMPLE_W-1:0] s1_old;
  logic [CIDX_W-1:0]            s1_idx;
  logic [SUM_W-1:0]             sum_r [CHANNEL_COUNT];
  logic [SUM_W-1:0]             sum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_live_r   <= in_live;
      s1_filled_r <= cur_filled;
      s1_chan_r   <= in_channel;
      s1_sample_r <= in_sample;
    end
  end

  // An entry of a ring that has not wrapped since reset was never written and counts as zero.
  assign s1_old  = s1_filled_r ? ram_rdata : '0;
  assign s1_idx  = CIDX_W'(s1_chan_r);
  assign sum_nxt = sum_r[s1_idx] - SUM_W'(s1_old) + SUM_W'(s1_sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        sum_r[i] <= '0;
      end
    end else if (adv && s1_valid_r && s1_live_r) begin
      sum_r[s1_idx] <= sum_nxt;
    end
  end

  // Stage 2: divide the sum by the window length through the reciprocal multiply.
  logic                         s2_valid_r, s2_live_r;
  logic [mma_pkg::CHAN_W-1:0]   s2_chan_r;
  logic [SUM_W-1:0]             s2_sum_r;
  logic [PROD_W-1:0]            s2_prod;
  mma_pkg::result_t             s2_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_live_r <= s1_live_r;
      s2_chan_r <= s1_chan_r;
      s2_sum_r  <= sum_nxt;
    end
  end

  assign s2_prod        = PROD_W'(s2_sum_r) * PROD_W'(RECIP_V);
  assign s2_result.chan = s2_chan_r;
  assign s2_result.avg  = s2_live_r ? mma_pkg::SAMPLE_W'(s2_prod >> SHIFT) : '0;

  // Output buffer.
  mma_pkg::result_t out_data;

  mma_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && s2_valid_r),
    .push_data (s2_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

  assign out_result_channel = out_data.chan;
  assign out_average        = out_data.avg;

  // A live item always finds its channel's pointer inside the window.
  `MMA_ASSERT_NOW(a_ptr_in_window, ram_en, cur_ptr <= PTR_LAST)
  // The running sum never exceeds a full window of maximum samples.
  `MMA_ASSERT_NOW(a_sum_bounded, s1_valid_r && s1_live_r, sum_nxt <= MAX_SUM)
  // An item leaving stage 1 arrives in stage 2 on the next cycle.
  `MMA_ASSERT_NEXT(a_stage_moves, adv && s1_valid_r, s2_valid_r)

endmodule

[sv/mma_ring_ram.sv]
// Sample ring memory: one port, read-first, registered read data.
module mma_ring_ram #(
  parameter int ADDR_W = 5
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ADDR_W-1:0]             addr,
  input  logic [mma_pkg::SAMPLE_W-1:0]  wdata,
  output logic [mma_pkg::SAMPLE_W-1:0]  rdata
);

  logic [mma_pkg::SAMPLE_W-1:0] mem [1 << ADDR_W];
  logic [mma_pkg::SAMPLE_W-1:0] rdata_r;

  // The old entry is read out in the same cycle the new sample replaces it.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r    <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/mma_out_buf.sv]
// Two-entry output buffer that decouples the result channel from the pipeline.
module mma_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mma_pkg::result_t push_data,
  input  logic             out_stall,
  output logic             out_valid,
  output mma_pkg::result_t out_data,
  output logic             full
);

  logic             head_valid_r, tail_valid_r;
  mma_pkg::result_t head_r, tail_r;
  logic             pop;

  assign pop = head_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      tail_valid_r <= 1'b0;
    end else if (pop) begin
      if (tail_valid_r) begin
        head_valid_r <= 1'b1;
        tail_valid_r <= push;
      end else begin
        head_valid_r <= push;
      end
    end else if (!head_valid_r) begin
      head_valid_r <= push;
    end else if (push) begin
      tail_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (tail_valid_r) begin
        head_r <= tail_r;
        if (push) begin
          tail_r <= push_data;
        end
      end else if (push) begin
        head_r <= push_data;
      end
    end else if (!head_valid_r) begin
      if (push) begin
        head_r <= push_data;
      end
    end else if (push) begin
      tail_r <= push_data;
    end
  end

  assign out_valid = head_valid_r;
  assign out_data  = head_r;
  assign full      = head_valid_r && tail_valid_r;

endmodule

[verif/testbench.sv]
// Self-checking testbench for the multichannel boxcar moving-average filter.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The window and channel count used by the predictor match the parameters of the instance.
  localparam int WINDOW_LEN   = 8;
  localparam int CHAN_COUNT   = 4;
  localparam int RANDOM_READS = 1300;
  // Percentage of cycles in which either side idles outside the quiet stretch.
  localparam int IDLE_PCT     = 7;
  // The quiet stretch: neither side idles while its transfer count lies in this range.
  localparam int QUIET_FIRST  = 600;
  localparam int QUIET_LAST   = 900;
  // The receiver holds off once, for this many cycles, after this many results.
  localparam int HOLDOFF_AT   = 300;
  localparam int HOLDOFF_LEN  = 80;
  // The pipeline is three stages deep; the drain gives it time to empty after the last result.
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_REPORTS  = 10;

  // One sensor read as it is offered on the input channel.
  typedef struct {
    logic [mma_pkg::CHAN_W-1:0] chan;
    logic [mma_pkg::BYTE_W-1:0] hi;
    logic [mma_pkg::BYTE_W-1:0] lo;
  } sensor_read_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [mma_pkg::CHAN_W-1:0]   in_channel;
  logic [mma_pkg::BYTE_W-1:0]   in_high_byte;
  logic [mma_pkg::BYTE_W-1:0]   in_low_byte;
  logic                         out_valid;
  logic                         out_stall;
  logic [mma_pkg::CHAN_W-1:0]   out_result_channel;
  logic [mma_pkg::SAMPLE_W-1:0] out_average;

  multichannel_moving_average_top #(
    .WINDOW_LENGTH(WINDOW_LEN),
    .CHANNEL_COUNT(CHAN_COUNT)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_channel        (in_channel),
    .in_high_byte      (in_high_byte),
    .in_low_byte       (in_low_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_channel(out_result_channel),
    .out_average       (out_average)
  );

  // Stimulus waiting to be offered, and the averages that accepted reads will produce.
  sensor_read_t     reads_to_send[$];
  mma_pkg::result_t expected_averages[$];

  // The predictor's own copy of the filter state: per-channel rings, slots and sums.
  logic [mma_pkg::SAMPLE_W-1:0] ring_samples[CHAN_COUNT][WINDOW_LEN];
  int unsigned                  ring_slot[CHAN_COUNT];
  int unsigned                  ring_total[CHAN_COUNT];

  int               reads_sent;
  int               reads_accepted;
  int               results_seen;
  int               error_count;
  int               idle_cycles;
  int               holdoff_left;
  bit               holdoff_done;
  bit               read_taken;
  sensor_read_t     next_read;
  sensor_read_t     taken_read;
  mma_pkg::result_t predicted;
  mma_pkg::result_t wanted;

  // The clock runs with an 8 ns period for the whole run.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Count a failure; only the first few get a line of their own so the log stays short.
  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Advance the model by one accepted read and return the average it should produce.
  // The sample is the high byte followed by the upper nibble of the low byte; the lower
  // nibble is discarded. The new sample replaces the oldest one in the channel's ring,
  // so the running sum loses that sample and gains the new one.
  task automatic predict_window_average(input sensor_read_t rd,
                                        output mma_pkg::result_t res);
    logic [mma_pkg::SAMPLE_W-1:0] sample;
    int unsigned                  slot;
    sample   = {rd.hi, rd.lo[mma_pkg::BYTE_W-1:mma_pkg::NIBBLE_W]};
    res.chan = rd.chan;
    res.avg  = '0;
    // A channel beyond the configured count leaves the state alone and reports zero.
    if (rd.chan < CHAN_COUNT) begin
      slot = ring_slot[rd.chan];
      ring_total[rd.chan] = ring_total[rd.chan] - ring_samples[rd.chan][slot] + sample;
      ring_samples[rd.chan][slot] = sample;
      // The slot wraps back to the start of the ring after the last entry.
      ring_slot[rd.chan] = (slot == WINDOW_LEN - 1) ? 0 : slot + 1;
      res.avg = mma_pkg::SAMPLE_W'(ring_total[rd.chan] / WINDOW_LEN);
    end
  endtask

  task automatic queue_read(input int chan, input int hi, input int lo);
    sensor_read_t rd;
    rd.chan = mma_pkg::CHAN_W'(chan);
    rd.hi   = mma_pkg::BYTE_W'(hi);
    rd.lo   = mma_pkg::BYTE_W'(lo);
    reads_to_send.push_back(rd);
  endtask

  // Input driver. A new read goes out at the falling edge once the previous one has been
  // transferred, or when nothing is on offer. A read that is held off by in_stall stays
  // on the bus unchanged until the filter takes it.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || read_taken) begin
      if (reads_to_send.size() != 0 &&
          ((reads_sent >= QUIET_FIRST && reads_sent < QUIET_LAST) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        next_read = reads_to_send.pop_front();
        in_channel   <= next_read.chan;
        in_high_byte <= next_read.hi;
        in_low_byte  <= next_read.lo;
        in_valid     <= 1'b1;
        reads_sent   <= reads_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver. It stalls at random, except in the quiet stretch. Once, after a few
  // hundred results, it holds off for a long stretch while the sender keeps offering
  // reads, so the pipeline and the output buffer fill and the filter raises in_stall.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
      out_stall    <= 1'b1;
      holdoff_left <= HOLDOFF_LEN - 1;
      holdoff_done <= 1'b1;
    end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor and checker, sampling at the rising edge. The result side is checked before
  // the input side predicts, so a result can never be matched against an expectation
  // that was queued in the same cycle. The watchdog ends the run when no transfer has
  // happened on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      read_taken  <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_averages.size() == 0) begin
          note_error($sformatf("unexpected result: channel %0d average %0d",
                               out_result_channel, out_average));
        end else begin
          wanted = expected_averages.pop_front();
          if (out_result_channel !== wanted.chan || out_average !== wanted.avg) begin
            note_error($sformatf("result mismatch: expected ch %0d avg %0d, got ch %0d avg %0d",
                                 wanted.chan, wanted.avg, out_result_channel, out_average));
          end
        end
      end

      read_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        taken_read.chan = in_channel;
        taken_read.hi   = in_high_byte;
        taken_read.lo   = in_low_byte;
        predict_window_average(taken_read, predicted);
        expected_averages.push_back(predicted);
        reads_accepted <= reads_accepted + 1;
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Reset, stimulus and end of run.
  initial begin : stimulus
    int total_reads;
    int burst_chan;
    int burst_len;
    int hi;
    int lo;
    int mode;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_channel     = '0;
    in_high_byte   = '0;
    in_low_byte    = '0;
    out_stall      = 1'b0;
    reads_sent     = 0;
    reads_accepted = 0;
    results_seen   = 0;
    error_count    = 0;
    idle_cycles    = 0;
    holdoff_left   = 0;
    holdoff_done   = 1'b0;
    read_taken     = 1'b0;

    // The filter comes out of reset with every slot and sum at zero, and unwritten ring entries count as zero.
    for (int c = 0; c < CHAN_COUNT; c++) begin
      ring_slot[c]  = 0;
      ring_total[c] = 0;
      for (int s = 0; s < WINDOW_LEN; s++) ring_samples[c][s] = '0;
    end

    // Directed part. Channel 3 gets nine full-scale reads back to back: the average ramps
    // up from zero, the slot wraps, and the sum reaches its largest value.
    for (int k = 0; k < WINDOW_LEN + 1; k++) queue_read(3, 8'hff, 8'hff);
    // Only the lower nibble set: the sample is zero because that nibble is dropped.
    queue_read(0, 8'h00, 8'h0f);
    queue_read(1, 8'h00, 8'hf0);
    queue_read(2, 8'hff, 8'h0f);
    queue_read(0, 8'h80, 8'hf0);
    queue_read(1, 8'ha5, 8'h5a);
    queue_read(2, 8'h5a, 8'ha5);
    // Zero samples into the full-scale channel pull its average down again.
    queue_read(3, 8'h00, 8'h00);
    queue_read(3, 8'h00, 8'h00);
    queue_read(0, 8'h01, 8'h10);
    queue_read(1, 8'hfe, 8'hef);
    queue_read(2, 8'h7f, 8'h80);
    queue_read(3, 8'h80, 8'h7f);

    // Random part. Three in ten draws are same-channel bursts, which carry most reads,
    // update one running sum back to back and push the slots through several wraps; the
    // rest has a random channel per read. Bytes are mostly uniform, extremes mixed in.
    while (reads_to_send.size() < RANDOM_READS + 21) begin
      mode       = $urandom_range(9);
      burst_chan = $urandom_range(CHAN_COUNT - 1);
      burst_len  = (mode < 3) ? $urandom_range(12, 2) : 1;
      for (int k = 0; k < burst_len; k++) begin
        case ($urandom_range(7))
          0:       hi = 8'h00;
          1:       hi = 8'hff;
          default: hi = $urandom_range(255);
        endcase
        case ($urandom_range(7))
          0:       lo = 8'h0f;
          1:       lo = 8'hf0;
          default: lo = $urandom_range(255);
        endcase
        queue_read((mode < 3) ? burst_chan : $urandom_range(CHAN_COUNT - 1), hi, lo);
      end
    end
    total_reads = reads_to_send.size();

    // Hold reset, then release it away from the sampling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every read has been transferred and every average has come back, then
    // let the filter run on through a drain in which any stray result would be caught.
    while (reads_accepted < total_reads || expected_averages.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_averages.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/mma_pkg.sv
sv/mma_ring_ram.sv
sv/mma_out_buf.sv
sv/multichannel_moving_average_top.sv
verif/testbench.sv
